[rtl/core/bcdp_pkg.sv]
// Shared types and constants for the button double-press run control block.
`default_nettype none

package bcdp_pkg;

   localparam int unsigned TICK_WIDTH      = 8;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_PRESS_TICKS     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOUBLE_WINDOW_TICKS = 2'd1;

   localparam logic [TICK_WIDTH-1:0] MIN_PRESS_TICKS_RESET     = 8'd8;
   localparam logic [TICK_WIDTH-1:0] DOUBLE_WINDOW_TICKS_RESET = 8'd50;

   typedef struct packed {
      logic key_level;
      logic force_stop;
   } req_type;

   typedef struct packed {
      logic click;
      logic running;
      logic armed;
      logic start_pulse;
      logic stop_pulse;
   } rsp_type;

   typedef struct packed {
      logic [TICK_WIDTH-1:0] min_press_ticks;
      logic [TICK_WIDTH-1:0] double_window_ticks;
   } cfg_type;

   typedef struct packed {
      logic [TICK_WIDTH-1:0] press_ticks;
      logic                  run_flag;
      logic                  arm_flag;
      logic [TICK_WIDTH-1:0] window_ticks;
   } state_type;

endpackage

`default_nettype wire

[rtl/core/bcdp_csr.sv]
// Configuration registers: minimum press length and double-press window.
`default_nettype none

module bcdp_csr (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [bcdp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [bcdp_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output bcdp_pkg::cfg_type                           cfg
);
   import bcdp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Writes to an index outside the register list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_PRESS_TICKS:     cfg_in.min_press_ticks     = csr_wdata;
            CSR_DOUBLE_WINDOW_TICKS: cfg_in.double_window_ticks = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_press_ticks     <= MIN_PRESS_TICKS_RESET;
         cfg_ff.double_window_ticks <= DOUBLE_WINDOW_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/bcdp_step.sv]
// Next-state and result logic for one key tick.
`default_nettype none

module bcdp_step #(
   parameter int unsigned PRESS_CAP = 200
) (
   input  wire bcdp_pkg::state_type state,
   input  wire bcdp_pkg::cfg_type   cfg,
   input  wire bcdp_pkg::req_type   req,
   output bcdp_pkg::state_type      state_next,
   output bcdp_pkg::rsp_type        rsp
);
   import bcdp_pkg::*;

   logic [TICK_WIDTH:0]   press_sum;
   logic [TICK_WIDTH:0]   window_sum;
   logic [TICK_WIDTH-1:0] press_new;
   logic                  click;
   logic                  run_k;
   logic                  arm_k;
   logic                  start_p;
   logic                  stop_p;
   logic [TICK_WIDTH-1:0] window_k;
   logic                  arm_w;
   logic [TICK_WIDTH-1:0] window_w;

   assign press_sum = {1'b0, state.press_ticks} + (TICK_WIDTH+1)'(1);

   always_comb begin
      // Key step: count while held (saturating), qualify on release.
      click = 1'b0;
      if (req.key_level) begin
         if (press_sum >= (TICK_WIDTH+1)'(PRESS_CAP)) begin
            press_new = TICK_WIDTH'(PRESS_CAP);
         end else begin
            press_new = press_sum[TICK_WIDTH-1:0];
         end
      end else begin
         click     = (state.press_ticks >= cfg.min_press_ticks);
         press_new = '0;
      end

      // Click step: arm, start or stop.
      run_k    = state.run_flag;
      arm_k    = state.arm_flag;
      window_k = state.window_ticks;
      start_p  = 1'b0;
      stop_p   = 1'b0;
      if (click) begin
         if (state.arm_flag) begin
            run_k   = 1'b1;
            arm_k   = 1'b0;
            start_p = 1'b1;
         end else if (state.run_flag) begin
            run_k  = 1'b0;
            arm_k  = 1'b0;
            stop_p = 1'b1;
         end else begin
            arm_k = 1'b1;
         end
         window_k = '0;
      end
   end

   assign window_sum = {1'b0, window_k} + (TICK_WIDTH+1)'(1);

   // Window step: an armed window counts released ticks and expires.
   always_comb begin
      arm_w    = arm_k;
      window_w = window_k;
      if ((press_new == '0) && arm_k) begin
         if (window_sum > {1'b0, cfg.double_window_ticks}) begin
            arm_w    = 1'b0;
            window_w = '0;
         end else begin
            window_w = window_sum[TICK_WIDTH-1:0];
         end
      end
   end

   always_comb begin
      state_next.press_ticks  = press_new;
      state_next.run_flag     = run_k && !req.force_stop;
      state_next.arm_flag     = arm_w;
      state_next.window_ticks = window_w;
      rsp.click               = click;
      rsp.running             = state_next.run_flag;
      rsp.armed               = arm_w;
      rsp.start_pulse         = start_p;
      rsp.stop_pulse          = stop_p;
   end

endmodule

`default_nettype wire

[rtl/core/button_click_double_press_run_control_core.sv]
// Top level of the button double-press run control block.
//
// Each req item is one 5 ms tick carrying the sampled key level and a stop
// request. For every item the block returns exactly one rsp item with the
// click flag, the run and armed state after the tick, and start and stop
// pulses. Both channels use valid and ready.
//
// The item passes an input register and then a result register, which drives
// rsp_valid. One item can be accepted in every cycle unless both registers are
// full: the tick logic is a single pass of small counters and flags, and the
// run state is updated in the same cycle the result is registered.
//
// When the receiver stalls, the result register holds its item and the input
// register holds the next one; req_ready drops only when both are full.
//
// The csr channel writes min_press_ticks (index 0) and double_window_ticks
// (index 1); other indexes are ignored. It is always ready, and writes are
// expected only while no item is in flight.
// Synchronous reset empties both registers, clears the press counter, run
// flag, armed flag and window counter, and restores register defaults.
`default_nettype none

module button_click_double_press_run_control_core #(
   parameter int unsigned PRESS_CAP = 200
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire bcdp_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output bcdp_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [bcdp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [bcdp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import bcdp_pkg::*;

   cfg_type   cfg;
   state_type state_ff;
   state_type state_in;
   rsp_type   step_rsp;

   logic      in_valid_ff;
   req_type   in_data_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;
   logic      advance;

   bcdp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bcdp_step #(
      .PRESS_CAP (PRESS_CAP)
   ) u_step (
      .state      (state_ff),
      .cfg        (cfg),
      .req        (in_data_ff),
      .state_next (state_in),
      .rsp        (step_rsp)
   );

   // The item in the input register moves on when the result slot is free
   // or is being emptied this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   // A tick can never both start and stop the run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.start_pulse && rsp_data.stop_pulse))
      else $error("start and stop pulse in the same item");

   // A start comes only from a click and leaves the window disarmed.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.start_pulse) |-> (rsp_data.click && !rsp_data.armed))
      else $error("start pulse without click or with armed window");

   // A stop leaves the block neither running nor armed.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.stop_pulse) |-> (!rsp_data.running && !rsp_data.armed))
      else $error("stop pulse left run or armed state set");

   // The press counter never passes its cap.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.press_ticks <= TICK_WIDTH'(PRESS_CAP))
      else $error("press counter above cap");

   // The state changes only when an item is processed.
   assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |-> $stable(state_ff))
      else $error("state changed without an item");

endmodule

`default_nettype wire
